@@ design/tkhde_pkg.sv @@
// ----------------------------------------------------------------------------
// tkhde_pkg
// Shared types, constants and lookup functions for the three-key hex digit
// editor: key event codes, segment and place tables, reset digit values.
// ----------------------------------------------------------------------------
`default_nettype none

package tkhde_pkg;

    // Digit count default, legal range 2..4
    localparam int NUM_DIGITS_DEF = 4;

    // Event queue between front and back
    localparam int EVQ_DEPTH = 2;

    // Configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic REG_THRESHOLD = 1'b0;   // register index bit paddr[2]
    localparam logic [7:0] THRESHOLD_RESET = 8'd10;

    // Marker ORed into the selected digit's pattern
    localparam logic [7:0] SEL_MARK = 8'h10;

    // Key acted on during a poll
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SELECT = 2'd1,
        EV_UP     = 2'd2,
        EV_DOWN   = 2'd3
    } key_event_t;

    // One queue request: a poll's event
    typedef struct packed {
        logic       valid;
        key_event_t ev;
    } evq_t;

    // Hex value to segment byte
    function automatic logic [7:0] seg_of(input logic [3:0] value);
        logic [7:0] pat;
        case (value)
            4'h0: pat = 8'haf;
            4'h1: pat = 8'ha0;
            4'h2: pat = 8'hc7;
            4'h3: pat = 8'he5;
            4'h4: pat = 8'he8;
            4'h5: pat = 8'h6d;
            4'h6: pat = 8'h6f;
            4'h7: pat = 8'ha1;
            4'h8: pat = 8'hef;
            4'h9: pat = 8'he9;
            4'ha: pat = 8'heb;
            4'hb: pat = 8'h6e;
            4'hc: pat = 8'h0f;
            4'hd: pat = 8'he6;
            4'he: pat = 8'h4f;
            default: pat = 8'h4b;
        endcase
        return pat;
    endfunction

    // Digit position to common-line place code
    function automatic logic [5:0] place_of(input logic [1:0] pos);
        logic [5:0] code;
        case (pos)
            2'd0: code = 6'h04;
            2'd1: code = 6'h20;
            2'd2: code = 6'h10;
            default: code = 6'h08;
        endcase
        return code;
    endfunction

    // Power-up digit values by position
    function automatic logic [3:0] reset_digit(input logic [1:0] pos);
        logic [3:0] value;
        case (pos)
            2'd0: value = 4'd4;
            2'd1: value = 4'd3;
            2'd2: value = 4'd2;
            default: value = 4'd1;
        endcase
        return value;
    endfunction

endpackage

`default_nettype wire

@@ design/three_key_hex_digit_editor_unit.sv @@
// ----------------------------------------------------------------------------
// three_key_hex_digit_editor_unit
// Three-key hex digit editor: debounces key polls and produces one
// seven-segment result per display digit for every poll.
// ----------------------------------------------------------------------------
// Each accepted poll yields NUM_DIGITS results, digit 0 first, with m_last on
// the final one. The back end sends one digit result per cycle while m_ready
// does not hold the output register, and takes the next queued poll as it
// loads the last result of the current one. From idle, a poll's event passes
// through the event queue and the idle state before its first result loads.
// A two-entry event queue sits between the key front end and the display
// back end; while m_ready holds results, polls are accepted until it is full.
// press_threshold (address 0) sets the poll count at which a held key counts
// as pressed; a value of zero means 256 polls.
`default_nettype none

module three_key_hex_digit_editor_unit #(
    parameter int NUM_DIGITS = tkhde_pkg::NUM_DIGITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // key poll requests
    input  wire logic                             s_valid,
    output      logic                             s_ready,
    input  wire logic                             s_key_one_pressed,
    input  wire logic                             s_key_two_pressed,
    input  wire logic                             s_key_three_pressed,
    // digit results
    output      logic                             m_valid,
    input  wire logic                             m_ready,
    output      logic [7:0]                       m_segment_pattern,
    output      logic [5:0]                       m_digit_enable,
    output      logic [1:0]                       m_key_event,
    output      logic                             m_last,
    // register port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tkhde_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [tkhde_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [tkhde_pkg::APB_DATA_W-1:0] prdata,
    output      logic                             pready
);

    logic [7:0]       threshold_reg;
    logic             reg_hit;
    logic             evq_full;
    logic             evq_pop;
    tkhde_pkg::evq_t  evq_push;
    tkhde_pkg::evq_t  evq_head;

    // Register file: one threshold register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == tkhde_pkg::REG_THRESHOLD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= tkhde_pkg::THRESHOLD_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            threshold_reg <= pwdata[7:0];
        end
    end

    assign prdata = reg_hit ? {{(tkhde_pkg::APB_DATA_W - 8){1'b0}}, threshold_reg} : '0;

    tkhde_front u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_key_one_pressed   (s_key_one_pressed),
        .s_key_two_pressed   (s_key_two_pressed),
        .s_key_three_pressed (s_key_three_pressed),
        .press_threshold     (threshold_reg),
        .evq_full            (evq_full),
        .evq_push            (evq_push)
    );

    tkhde_evq u_evq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (evq_push),
        .full    (evq_full),
        .head    (evq_head),
        .pop     (evq_pop)
    );

    tkhde_back #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .evq_head          (evq_head),
        .evq_pop           (evq_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_segment_pattern (m_segment_pattern),
        .m_digit_enable    (m_digit_enable),
        .m_key_event       (m_key_event),
        .m_last            (m_last)
    );

endmodule

`default_nettype wire

@@ design/tkhde_front.sv @@
// ----------------------------------------------------------------------------
// tkhde_front
// Accepts key polls, runs the press counter and hold logic, and queues one
// key event per poll for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tkhde_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output      logic             s_ready,
    input  wire logic             s_key_one_pressed,
    input  wire logic             s_key_two_pressed,
    input  wire logic             s_key_three_pressed,
    input  wire logic [7:0]       press_threshold,
    input  wire logic             evq_full,
    output      tkhde_pkg::evq_t  evq_push
);

    logic [7:0]            count_reg, count_next;
    logic                  held_reg, held_next;
    tkhde_pkg::key_event_t capt_reg, capt_next;
    tkhde_pkg::key_event_t key;
    tkhde_pkg::key_event_t ev;
    logic                  accept;

    assign s_ready = !evq_full;
    assign accept  = s_valid && s_ready;

    // Priority: key one over key two over key three
    always_comb begin
        if (s_key_one_pressed) begin
            key = tkhde_pkg::EV_SELECT;
        end else if (s_key_two_pressed) begin
            key = tkhde_pkg::EV_UP;
        end else if (s_key_three_pressed) begin
            key = tkhde_pkg::EV_DOWN;
        end else begin
            key = tkhde_pkg::EV_NONE;
        end
    end

    // Press counter, hold flag and capture
    always_comb begin
        count_next = count_reg;
        held_next  = held_reg;
        capt_next  = capt_reg;
        ev         = tkhde_pkg::EV_NONE;
        if (key != tkhde_pkg::EV_NONE) begin
            count_next = count_reg + 8'd1;
            if (count_next == press_threshold) begin
                held_next = 1'b1;
                capt_next = key;
            end
        end else begin
            count_next = 8'd0;
            if (held_reg) begin
                held_next = 1'b0;
                ev        = capt_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 8'd0;
            held_reg  <= 1'b0;
            capt_reg  <= tkhde_pkg::EV_NONE;
        end else if (accept) begin
            count_reg <= count_next;
            held_reg  <= held_next;
            capt_reg  <= capt_next;
        end
    end

    // Every accepted poll queues its event, none included
    assign evq_push.valid = accept;
    assign evq_push.ev    = ev;

endmodule

`default_nettype wire

@@ design/tkhde_evq.sv @@
// ----------------------------------------------------------------------------
// tkhde_evq
// Short queue of key events between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tkhde_evq (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire tkhde_pkg::evq_t  push,
    output      logic             full,
    output      tkhde_pkg::evq_t  head,
    input  wire logic             pop
);

    localparam int DEPTH = tkhde_pkg::EVQ_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tkhde_pkg::key_event_t slot_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]      fill_reg;
    logic                  do_push, do_pop;

    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign do_push = push.valid && !full;
    assign do_pop  = pop && (fill_reg != '0);

    assign head.valid = (fill_reg != '0);
    assign head.ev    = slot_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.ev;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ design/tkhde_back.sv @@
// ----------------------------------------------------------------------------
// tkhde_back
// Applies queued key events to the selected digit and digit values, then
// sends one display result per digit through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tkhde_back #(
    parameter int NUM_DIGITS = tkhde_pkg::NUM_DIGITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire tkhde_pkg::evq_t  evq_head,
    output      logic             evq_pop,
    output      logic             m_valid,
    input  wire logic             m_ready,
    output      logic [7:0]       m_segment_pattern,
    output      logic [5:0]       m_digit_enable,
    output      logic [1:0]       m_key_event,
    output      logic             m_last
);

    localparam int POS_W = $clog2(NUM_DIGITS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [POS_W-1:0]      sel_reg;
    logic [3:0]            digit_reg [NUM_DIGITS];
    tkhde_pkg::key_event_t ev_reg;
    logic                  out_valid_reg;
    logic [7:0]            seg_reg;
    logic [5:0]            place_reg;
    logic [1:0]            event_reg;
    logic                  last_reg;
    logic                  load_ok;
    logic                  load;
    logic                  pos_is_last;
    logic [7:0]            seg_now;

    assign load_ok     = !out_valid_reg || m_ready;
    assign pos_is_last = (pos_reg == POS_W'(NUM_DIGITS - 1));

    // Sequencer: take an event, then walk the digits
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        load       = 1'b0;
        evq_pop    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (evq_head.valid) begin
                    evq_pop    = 1'b1;
                    state_next = ST_EMIT;
                    pos_next   = '0;
                end
            end
            ST_EMIT: begin
                if (load_ok) begin
                    load = 1'b1;
                    if (pos_is_last) begin
                        pos_next = '0;
                        // chain straight into the next poll if one waits
                        if (evq_head.valid) begin
                            evq_pop = 1'b1;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
                pos_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // Edit state: selection and digit values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= '0;
            ev_reg  <= tkhde_pkg::EV_NONE;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                digit_reg[i] <= tkhde_pkg::reset_digit(2'(i));
            end
        end else if (evq_pop) begin
            ev_reg <= evq_head.ev;
            if (evq_head.ev == tkhde_pkg::EV_SELECT) begin
                sel_reg <= (sel_reg == POS_W'(NUM_DIGITS - 1)) ? '0 : sel_reg + POS_W'(1);
            end
            for (int i = 0; i < NUM_DIGITS; i++) begin
                if (sel_reg == POS_W'(i)) begin
                    if (evq_head.ev == tkhde_pkg::EV_UP) begin
                        digit_reg[i] <= digit_reg[i] + 4'd1;
                    end else if (evq_head.ev == tkhde_pkg::EV_DOWN) begin
                        digit_reg[i] <= digit_reg[i] - 4'd1;
                    end
                end
            end
        end
    end

    // Pattern of the current digit, marked when selected
    assign seg_now = tkhde_pkg::seg_of(digit_reg[pos_reg])
                   | ((pos_reg == sel_reg) ? tkhde_pkg::SEL_MARK : 8'h00);

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            seg_reg   <= seg_now;
            place_reg <= tkhde_pkg::place_of(2'(pos_reg));
            event_reg <= ev_reg;
            last_reg  <= pos_is_last;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_segment_pattern = seg_reg;
    assign m_digit_enable    = place_reg;
    assign m_key_event       = event_reg;
    assign m_last            = last_reg;

endmodule

`default_nettype wire

@@ design/tkhde_checker.sv @@
// ----------------------------------------------------------------------------
// tkhde_checker
// Port-level checks for the hex digit editor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tkhde_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_segment_pattern,
    input wire logic [5:0] m_digit_enable,
    input wire logic [1:0] m_key_event,
    input wire logic       m_last
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_segment_pattern)
            && $stable(m_digit_enable) && $stable(m_key_event) && $stable(m_last))
        else $error("result changed while stalled");

    // Each result drives exactly one common line
    a_place_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot(m_digit_enable))
        else $error("place code not one-hot");

    // Digits of one poll follow back to back
    a_digits_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("gap inside a poll's results");

    // Out of reset: nothing pending, ready for a poll
    a_reset_state: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid && s_ready)
        else $error("bad state after reset");

endmodule

bind three_key_hex_digit_editor_unit tkhde_checker u_tkhde_checker (.*);

`default_nettype wire
